FILE: rtl/slcan_pkg.sv
package slcan_pkg;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_STD   = 2'd1,
        KIND_EXT   = 2'd2,
        KIND_OTHER = 2'd3
    } kind_t;

    localparam logic [4:0] STD_MIN_LEN   = 5'd6;
    localparam logic [4:0] EXT_MIN_LEN   = 5'd11;
    localparam logic [4:0] STD_ID_DIGITS = 5'd3;
    localparam logic [4:0] EXT_ID_DIGITS = 5'd8;
    localparam logic [4:0] DATA_DIGITS   = 5'd16;
    localparam logic [4:0] POS_MAX       = 5'd31;
    localparam logic [3:0] MAX_BYTES     = 4'd8;

    localparam logic [7:0] CHAR_STD   = 8'h74; // 't'
    localparam logic [7:0] CHAR_EXT   = 8'h54; // 'T'
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_F  = 8'h66;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_F  = 8'h46;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t   h;
        logic [7:0] d;
        h = '0;
        d = '0;
        if (c >= CHAR_0 && c <= CHAR_9)
        begin
            d = c - CHAR_0;
            h.valid = 1'b1;
            h.value = d[3:0];
        end
        else if (c >= CHAR_LC_A && c <= CHAR_LC_F)
        begin
            d = c - CHAR_LC_A + 8'd10;
            h.valid = 1'b1;
            h.value = d[3:0];
        end
        else if (c >= CHAR_UC_A && c <= CHAR_UC_F)
        begin
            d = c - CHAR_UC_A + 8'd10;
            h.valid = 1'b1;
            h.value = d[3:0];
        end
        return h;
    endfunction

endpackage

FILE: rtl/slcan_text_to_can_frame_core.sv
// Serial-CAN transmit line parser.
// Input channel (in_valid/in_ready): one ASCII character per item in char_in;
// end_of_line marks the last character of a command line. A line starting
// with 't' is a standard frame (3 id digits), 'T' an extended one (8 digits),
// followed by one length digit and two hex digits per data byte.
// Output channel (out_valid/out_ready): one frame per accepted line that is
// long enough (more than 6 or 11 characters); other lines give no item.
// Throughput: one character per cycle unless the output stalls it. Each
// character goes through a single update stage on the line state registers;
// the frame is registered in the output register in the same edge that
// accepts the end-of-line character, so out_valid rises in the next cycle.
// A frame waits in the output register until taken; while it waits and
// out_ready is low, in_ready is low. When out_ready is high the next
// character is taken in the same cycle the frame leaves.
// Reset clears the line state and out_valid; the first character after
// reset starts a new line.
module slcan_text_to_can_frame_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_in,
    input  logic        end_of_line,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        is_extended,
    output logic [31:0] frame_id,
    output logic [3:0]  data_length,
    output logic [63:0] payload
);

    logic                 accept;
    logic [4:0]           pos_reg, pos_next;
    slcan_pkg::kind_t     kind_reg, kind_next;
    logic [31:0]          id_reg, id_next;
    logic                 id_stop_reg, id_stop_next;
    logic [3:0]           len_reg, len_next;
    logic [63:0]          pay_reg, pay_next;
    logic                 byte_stop_reg, byte_stop_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 ext_out_reg, ext_out_next;
    logic [31:0]          id_out_reg, id_out_next;
    logic [3:0]           len_out_reg, len_out_next;
    logic [63:0]          pay_out_reg, pay_out_next;

    slcan_pkg::hex_t      hex;
    logic [4:0]           id_digits;
    logic [4:0]           off;
    logic [2:0]           idx;
    logic [7:0]           prev_byte;
    logic [7:0]           dig;
    logic                 std_ok, ext_ok;

    assign accept   = in_valid && in_ready;
    assign in_ready = !out_valid_reg || out_ready;
    assign hex      = slcan_pkg::hex_decode(char_in);
    assign id_digits = (kind_reg == slcan_pkg::KIND_EXT) ? slcan_pkg::EXT_ID_DIGITS
                                                         : slcan_pkg::STD_ID_DIGITS;
    assign off       = pos_reg - (id_digits + 5'd2);
    assign idx       = off[3:1];
    assign prev_byte = pay_reg[{idx, 3'b000} +: 8];
    assign dig       = char_in - slcan_pkg::CHAR_0;

    always_comb
    begin
        pos_next       = pos_reg;
        kind_next      = kind_reg;
        id_next        = id_reg;
        id_stop_next   = id_stop_reg;
        len_next       = len_reg;
        pay_next       = pay_reg;
        byte_stop_next = byte_stop_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ext_out_next   = ext_out_reg;
        id_out_next    = id_out_reg;
        len_out_next   = len_out_reg;
        pay_out_next   = pay_out_reg;
        std_ok         = 1'b0;
        ext_ok         = 1'b0;

        if (accept)
        begin
            if (pos_reg == 5'd0)
            begin
                id_next        = '0;
                id_stop_next   = 1'b0;
                len_next       = '0;
                pay_next       = '0;
                byte_stop_next = 1'b0;
                if (char_in == slcan_pkg::CHAR_STD)
                    kind_next = slcan_pkg::KIND_STD;
                else if (char_in == slcan_pkg::CHAR_EXT)
                    kind_next = slcan_pkg::KIND_EXT;
                else
                    kind_next = slcan_pkg::KIND_OTHER;
            end
            else if (kind_reg == slcan_pkg::KIND_STD || kind_reg == slcan_pkg::KIND_EXT)
            begin
                if (pos_reg <= id_digits)
                begin
                    if (!id_stop_reg)
                    begin
                        if (hex.valid)
                            id_next = {id_reg[27:0], hex.value};
                        else
                            id_stop_next = 1'b1;
                    end
                end
                else if (pos_reg == id_digits + 5'd1)
                begin
                    if (char_in >= slcan_pkg::CHAR_0 && char_in <= slcan_pkg::CHAR_9)
                        len_next = (dig[3:0] > slcan_pkg::MAX_BYTES) ? slcan_pkg::MAX_BYTES
                                                                     : dig[3:0];
                    else
                        len_next = '0;
                end
                else if (pos_reg < id_digits + 5'd2 + slcan_pkg::DATA_DIGITS)
                begin
                    // even offset opens a byte, odd offset completes it
                    if (!off[0])
                    begin
                        byte_stop_next = !hex.valid;
                        pay_next[{idx, 3'b000} +: 8] = hex.valid ? {4'h0, hex.value} : 8'h00;
                    end
                    else if (!byte_stop_reg && hex.valid)
                    begin
                        pay_next[{idx, 3'b000} +: 8] = {prev_byte[3:0], hex.value};
                    end
                end
            end

            if (pos_reg != slcan_pkg::POS_MAX)
                pos_next = pos_reg + 5'd1;

            if (end_of_line)
            begin
                std_ok = (kind_next == slcan_pkg::KIND_STD) && (pos_next > slcan_pkg::STD_MIN_LEN);
                ext_ok = (kind_next == slcan_pkg::KIND_EXT) && (pos_next > slcan_pkg::EXT_MIN_LEN);
                if (std_ok || ext_ok)
                begin
                    out_valid_next = 1'b1;
                    ext_out_next   = ext_ok;
                    id_out_next    = id_next;
                    len_out_next   = len_next;
                    for (int i = 0; i < 8; i++)
                        pay_out_next[i*8 +: 8] = (4'(i) < len_next) ? pay_next[i*8 +: 8]
                                                                    : 8'h00;
                end
                pos_next       = '0;
                kind_next      = slcan_pkg::KIND_NONE;
                id_next        = '0;
                id_stop_next   = 1'b0;
                len_next       = '0;
                pay_next       = '0;
                byte_stop_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            kind_reg      <= slcan_pkg::KIND_NONE;
            id_reg        <= '0;
            id_stop_reg   <= 1'b0;
            len_reg       <= '0;
            pay_reg       <= '0;
            byte_stop_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            kind_reg      <= kind_next;
            id_reg        <= id_next;
            id_stop_reg   <= id_stop_next;
            len_reg       <= len_next;
            pay_reg       <= pay_next;
            byte_stop_reg <= byte_stop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ext_out_reg <= ext_out_next;
        id_out_reg  <= id_out_next;
        len_out_reg <= len_out_next;
        pay_out_reg <= pay_out_next;
    end

    assign out_valid   = out_valid_reg;
    assign is_extended = ext_out_reg;
    assign frame_id    = id_out_reg;
    assign data_length = len_out_reg;
    assign payload     = pay_out_reg;

    // line state: a started line always has a known kind
    a_pos_kind: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg != 5'd0 |-> kind_reg != slcan_pkg::KIND_NONE)
        else $error("line started without kind");

    a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_line |=> pos_reg == 5'd0 && kind_reg == slcan_pkg::KIND_NONE)
        else $error("line state not cleared after end of line");

    a_len_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> data_length <= slcan_pkg::MAX_BYTES)
        else $error("data length above clamp");

    a_std_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_extended |-> frame_id[31:12] == 20'd0)
        else $error("standard id wider than three digits");

    a_pay_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && data_length < slcan_pkg::MAX_BYTES
            |-> (payload >> {data_length[2:0], 3'b000}) == 64'd0)
        else $error("payload bytes beyond length not zero");

endmodule

FILE: tb/tb_slcan_text_to_can_frame_core.sv
`timescale 1ns / 100ps

module tb_slcan_text_to_can_frame_core;

    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_LEN   = 120;
    localparam int SETTLE     = 4;

    typedef struct packed {
        logic        ext;
        logic [31:0] id;
        logic [3:0]  len;
        logic [63:0] data;
    } can_frame_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  char_in = 8'h00;
    logic        end_of_line = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        is_extended;
    logic [31:0] frame_id;
    logic [3:0]  data_length;
    logic [63:0] payload;

    // line parser state mirrored from the block
    logic [4:0]        ln_pos;
    slcan_pkg::kind_t  ln_kind;
    logic [31:0]       ln_id;
    logic              ln_id_stop;
    logic [3:0]        ln_len;
    logic [63:0]       ln_data;
    logic              ln_byte_stop;

    can_frame_t  frames_due[$];
    can_frame_t  want;
    logic [7:0]  line_buf[$];

    int mismatches = 0;
    int chars_sent = 0;
    int frames_seen = 0;
    int idle_cycles = 0;
    int gap_max = 0;
    int burst_left = 0;
    int rx_stall_pct = 0;
    int stall_run = 0;
    int hold_ticket = 0;
    int hold_seen = 0;
    int hold_cnt = 0;

    slcan_text_to_can_frame_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .char_in     (char_in),
        .end_of_line (end_of_line),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .is_extended (is_extended),
        .frame_id    (frame_id),
        .data_length (data_length),
        .payload     (payload)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // {valid, value}
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= slcan_pkg::CHAR_0 && c <= slcan_pkg::CHAR_9)
        begin
            d = c - slcan_pkg::CHAR_0;
            return {1'b1, d[3:0]};
        end
        if (c >= slcan_pkg::CHAR_LC_A && c <= slcan_pkg::CHAR_LC_F)
        begin
            d = c - slcan_pkg::CHAR_LC_A + 8'd10;
            return {1'b1, d[3:0]};
        end
        if (c >= slcan_pkg::CHAR_UC_A && c <= slcan_pkg::CHAR_UC_F)
        begin
            d = c - slcan_pkg::CHAR_UC_A + 8'd10;
            return {1'b1, d[3:0]};
        end
        return 5'b0;
    endfunction

    task automatic clear_line_state();
        ln_pos       = '0;
        ln_kind      = slcan_pkg::KIND_NONE;
        ln_id        = '0;
        ln_id_stop   = 1'b0;
        ln_len       = '0;
        ln_data      = '0;
        ln_byte_stop = 1'b0;
    endtask

    task automatic parse_frame_char(input logic [7:0] c);
        int          p;
        int          ndig;
        int          off;
        int          idx;
        logic [4:0]  nib;
        logic [7:0]  d;
        p    = int'(ln_pos);
        nib  = nibble_of(c);
        ndig = (ln_kind == slcan_pkg::KIND_STD) ? int'(slcan_pkg::STD_ID_DIGITS)
                                                : int'(slcan_pkg::EXT_ID_DIGITS);
        if (p >= 1 && p <= ndig)
        begin
            if (!ln_id_stop)
            begin
                if (nib[4])
                    ln_id = {ln_id[27:0], nib[3:0]};
                else
                    ln_id_stop = 1'b1;
            end
        end
        else if (p == ndig + 1)
        begin
            if (c >= slcan_pkg::CHAR_0 && c <= slcan_pkg::CHAR_9)
            begin
                d = c - slcan_pkg::CHAR_0;
                ln_len = (d > slcan_pkg::MAX_BYTES) ? slcan_pkg::MAX_BYTES : d[3:0];
            end
            else
                ln_len = '0;
        end
        else if (p >= ndig + 2 && p < ndig + 2 + int'(slcan_pkg::DATA_DIGITS))
        begin
            off = p - (ndig + 2);
            idx = off >> 1;
            if (off % 2 == 0)
            begin
                ln_byte_stop = !nib[4];
                ln_data[idx*8 +: 8] = nib[4] ? {4'h0, nib[3:0]} : 8'h00;
            end
            else if (!ln_byte_stop && nib[4])
                ln_data[idx*8 +: 8] = {ln_data[idx*8 +: 4], nib[3:0]};
        end
    endtask

    task automatic predict_char(input logic [7:0] c, input logic eol);
        logic       std_ok;
        logic       ext_ok;
        can_frame_t fr;
        if (ln_pos == 5'd0)
        begin
            clear_line_state();
            if (c == slcan_pkg::CHAR_STD)
                ln_kind = slcan_pkg::KIND_STD;
            else if (c == slcan_pkg::CHAR_EXT)
                ln_kind = slcan_pkg::KIND_EXT;
            else
                ln_kind = slcan_pkg::KIND_OTHER;
        end
        else if (ln_kind == slcan_pkg::KIND_STD || ln_kind == slcan_pkg::KIND_EXT)
            parse_frame_char(c);

        if (ln_pos < slcan_pkg::POS_MAX)
            ln_pos = ln_pos + 5'd1;

        if (eol)
        begin
            std_ok = (ln_kind == slcan_pkg::KIND_STD) && (ln_pos > slcan_pkg::STD_MIN_LEN);
            ext_ok = (ln_kind == slcan_pkg::KIND_EXT) && (ln_pos > slcan_pkg::EXT_MIN_LEN);
            if (std_ok || ext_ok)
            begin
                fr.ext  = ext_ok;
                fr.id   = ln_id;
                fr.len  = ln_len;
                fr.data = (ln_len >= slcan_pkg::MAX_BYTES) ? ln_data
                        : ln_data & ((64'd1 << (ln_len * 8)) - 64'd1);
                frames_due.push_back(fr);
            end
            clear_line_state();
        end
    endtask

    task automatic note_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    // one character; bursts end in a random gap when gap_max is set
    task automatic send_char(input logic [7:0] c, input logic eol);
        in_valid    <= 1'b1;
        char_in     <= c;
        end_of_line <= eol;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_char(c, eol);
        chars_sent++;
        if (gap_max > 0)
        begin
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
                burst_left = $urandom_range(0, 16);
            end
            else
                burst_left--;
        end
    endtask

    task automatic send_line();
        foreach (line_buf[i])
            send_char(line_buf[i], i == line_buf.size() - 1);
    endtask

    task automatic send_text(input string s);
        line_buf.delete();
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
        send_line();
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [7:0] rand_hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
            return slcan_pkg::CHAR_0 + 8'(v);
        if ($urandom_range(0, 1))
            return slcan_pkg::CHAR_LC_A + 8'(v - 10);
        return slcan_pkg::CHAR_UC_A + 8'(v - 10);
    endfunction

    task automatic build_random_line();
        int roll;
        int ndig;
        int dlc;
        int ndata;
        int v;
        int n;
        line_buf.delete();
        roll = $urandom_range(0, 99);
        if (roll < 80)
        begin
            // mostly well-formed frames with random content
            ndig = $urandom_range(0, 1) ? int'(slcan_pkg::EXT_ID_DIGITS)
                                        : int'(slcan_pkg::STD_ID_DIGITS);
            line_buf.push_back(ndig == int'(slcan_pkg::EXT_ID_DIGITS) ? slcan_pkg::CHAR_EXT
                                                                      : slcan_pkg::CHAR_STD);
            repeat (ndig) line_buf.push_back(rand_hex_char());
            v = $urandom_range(0, 19);
            if (v < 10)
            begin
                dlc = v;
                line_buf.push_back(slcan_pkg::CHAR_0 + 8'(v));
            end
            else if (v < 18)
            begin
                dlc = $urandom_range(0, 8);
                line_buf.push_back(slcan_pkg::CHAR_0 + 8'(dlc));
            end
            else
            begin
                dlc = 8;
                line_buf.push_back(8'($urandom_range(0, 255)));
            end
            ndata = 2 * ((dlc > 8) ? 8 : dlc);
            v = $urandom_range(0, 9);
            if (v == 0)
                ndata = $urandom_range(0, ndata);
            repeat (ndata) line_buf.push_back(rand_hex_char());
            if (v == 1)
                repeat ($urandom_range(1, 6)) line_buf.push_back(rand_hex_char());
            if ($urandom_range(0, 9) == 0)
                line_buf[$urandom_range(1, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
        end
        else if (roll < 90)
        begin
            n = $urandom_range(1, 35);
            repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1))
                line_buf[0] = $urandom_range(0, 1) ? slcan_pkg::CHAR_EXT : slcan_pkg::CHAR_STD;
        end
        else
        begin
            // lengths around the minimum line length
            line_buf.push_back($urandom_range(0, 1) ? slcan_pkg::CHAR_EXT : slcan_pkg::CHAR_STD);
            repeat ($urandom_range(0, 12)) line_buf.push_back(rand_hex_char());
        end
    endtask

    task automatic random_lines_until(input int goal);
        while (chars_sent < goal)
        begin
            build_random_line();
            send_line();
        end
    endtask

    task automatic test_directed();
        gap_max      = 0;
        rx_stall_pct = 0;
        send_text("t");
        send_text("t12300");
        send_text("t123000");
        send_text("t7FF80011223344556677");
        send_text("T1FFFFFFF8FFEEDDCCBBAA9988");
        send_text("TFFFFFFFF00");
        send_text("TFFFFFFFF001");
        send_text("Tabcdef019deadbeefcafef00d");
        send_text("t123x55");
        send_text("t1G34AABBCCDD");
        send_text("t1234aZGbcD");
        send_text("t12384ABC");
        send_text("t12320102FFFF");
        send_text("r1238AABBCCDD");
        send_text("t12380123456789abcdefABCDEF0123456789abcd");
        drain();
    endtask

    task automatic test_random_traffic();
        gap_max      = 8;
        rx_stall_pct = 30;
        random_lines_until(chars_sent + 250);
        drain();
    endtask

    // receiver holds off while short frames keep coming
    task automatic test_output_holdoff();
        gap_max      = 0;
        rx_stall_pct = 0;
        hold_ticket++;
        repeat (12)
        begin
            line_buf.delete();
            line_buf.push_back(slcan_pkg::CHAR_STD);
            repeat (3) line_buf.push_back(rand_hex_char());
            line_buf.push_back(slcan_pkg::CHAR_0 + 8'd1);
            repeat (2) line_buf.push_back(rand_hex_char());
            send_line();
        end
        drain();
    endtask

    task automatic test_full_rate();
        gap_max      = 0;
        rx_stall_pct = 0;
        random_lines_until(chars_sent + 120);
        drain();
    endtask

    always @(posedge clk)
    begin
        if (hold_ticket != hold_seen)
        begin
            hold_seen <= hold_ticket;
            hold_cnt  <= HOLD_LEN;
            out_ready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt  <= hold_cnt - 1;
            out_ready <= 1'b0;
        end
        else if (stall_run > 0)
        begin
            stall_run <= stall_run - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct)
                stall_run <= $urandom_range(1, 6);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            frames_seen++;
            if (frames_due.size() == 0)
                note_error($sformatf("frame with none due: ext=%b id=%h len=%0d data=%h",
                                     is_extended, frame_id, data_length, payload));
            else
            begin
                want = frames_due.pop_front();
                if (is_extended !== want.ext)
                    note_error($sformatf("is_extended exp %b got %b", want.ext, is_extended));
                if (frame_id !== want.id)
                    note_error($sformatf("frame_id exp %h got %h", want.id, frame_id));
                if (data_length !== want.len)
                    note_error($sformatf("data_length exp %0d got %0d", want.len, data_length));
                if (payload !== want.data)
                    note_error($sformatf("payload exp %h got %h", want.data, payload));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        clear_line_state();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic();
        test_output_holdoff();
        test_full_rate();

        if (frames_due.size() != 0)
            note_error($sformatf("%0d frames never arrived", frames_due.size()));
        $display("Covered %0d characters and %0d frames: corner lines, throttled random",
                 chars_sent, frames_seen);
        $display("traffic, a long output hold-off and full-rate input; %0d mismatches.",
                 mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
